// ===== hdl/quaternion_to_euler_angles_assert.svh =====
// quaternion_to_euler_angles_assert.svh
// Assertion macros for the quaternion to Euler angle RTL. No dependencies;
// the including module must provide i_clk and i_rst_n.
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define QTE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define QTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/qte_pkg.sv =====
// qte_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the
// quaternion to Euler angle pipeline. No dependencies.
package qte_pkg;

    // Inputs wider than this are floored to it before the products.
    localparam int EFF_MAX = 28;

    // Pitch sine operand: Q28 fixed point, 30 bits signed.
    localparam int S28_W    = 30;
    localparam int S28_FRAC = 28;

    // Square-root operand 2^56 - s^2 and its root.
    localparam int RAD_W      = 57;
    localparam int ROOT_W     = 29;
    localparam int SQRT_STEPS = 29;
    localparam int SQRT_LAT   = 2 + SQRT_STEPS;
    localparam logic [RAD_W-1:0] RAD_ONE = {1'b1, {(RAD_W-1){1'b0}}};

    // Arctangent unit.
    localparam int NORM_TOP      = 38;
    localparam int NORM_STEPS    = 6;
    localparam int CORDIC_STAGES = 20;
    localparam int ATAN_LAT      = 2 + NORM_STEPS + CORDIC_STAGES;

    // Angles are degrees * 2^16.
    localparam int ANG_SCALE_BITS = 16;
    localparam int Z_W   = 24;
    localparam int ANG_W = 25;
    localparam logic signed [ANG_W-1:0] DEG90  = 25'sd5898240;
    localparam logic signed [ANG_W-1:0] DEG180 = 25'sd11796480;

    // Result field widths.
    localparam int ROLL_W  = 16;
    localparam int PITCH_W = 15;
    localparam int YAW_W   = 16;

    typedef struct packed {
        logic neg_num;
        logic neg_den;
        logic zero;
    } t_atan_flags;

    function automatic int eff_width(input int qw);
        return (qw > EFF_MAX) ? EFF_MAX : qw;
    endfunction

    // Width of the atan2 operands built from the quaternion products.
    function automatic int sum_width(input int qw);
        return 2 * eff_width(qw) + 3;
    endfunction

    // atan(2^-i) in degrees * 2^16, rounded to nearest.
    function automatic logic signed [Z_W-1:0] atan_entry(input int idx);
        logic signed [Z_W-1:0] v;
        unique case (idx)
            0:       v = 24'sd2949120;
            1:       v = 24'sd1740967;
            2:       v = 24'sd919879;
            3:       v = 24'sd466945;
            4:       v = 24'sd234379;
            5:       v = 24'sd117304;
            6:       v = 24'sd58666;
            7:       v = 24'sd29335;
            8:       v = 24'sd14668;
            9:       v = 24'sd7334;
            10:      v = 24'sd3667;
            11:      v = 24'sd1833;
            12:      v = 24'sd917;
            13:      v = 24'sd458;
            14:      v = 24'sd229;
            15:      v = 24'sd115;
            16:      v = 24'sd57;
            17:      v = 24'sd29;
            18:      v = 24'sd14;
            19:      v = 24'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/qte_front.sv =====
// qte_front.sv
// Two-stage front end: quaternion products, then the atan2 operands and
// the clamped pitch sine. Depends on qte_pkg.
module qte_front #(
    parameter int QUAT_WIDTH = 16
) (
    input  logic                                               i_clk,
    input  logic                                               i_en,
    input  logic signed [QUAT_WIDTH-1:0]                       i_quat_w,
    input  logic signed [QUAT_WIDTH-1:0]                       i_quat_x,
    input  logic signed [QUAT_WIDTH-1:0]                       i_quat_y,
    input  logic signed [QUAT_WIDTH-1:0]                       i_quat_z,
    output logic signed [qte_pkg::sum_width(QUAT_WIDTH)-1:0]   o_rn,
    output logic signed [qte_pkg::sum_width(QUAT_WIDTH)-1:0]   o_rd,
    output logic signed [qte_pkg::sum_width(QUAT_WIDTH)-1:0]   o_yn,
    output logic signed [qte_pkg::sum_width(QUAT_WIDTH)-1:0]   o_yd,
    output logic signed [qte_pkg::S28_W-1:0]                   o_s28
);

    localparam int EFF   = qte_pkg::eff_width(QUAT_WIDTH);
    localparam int SW    = qte_pkg::sum_width(QUAT_WIDTH);
    localparam int PW    = 2 * EFF;
    localparam int FRAC2 = 2 * (EFF - 2);
    localparam int S28W  = qte_pkg::S28_W;
    localparam int S28F  = qte_pkg::S28_FRAC;
    localparam logic signed [SW-1:0] ONE2 = SW'(64'sd1 <<< FRAC2);

    logic signed [EFF-1:0] w_e, x_e, y_e, z_e;
    logic signed [PW-1:0]  r_wx, r_yz, r_xx, r_yy, r_wz, r_xy, r_zz, r_wy, r_zx;
    logic signed [SW-1:0]  n_rn, n_rd, n_yn, n_yd, n_s;
    logic signed [SW-1:0]  r_rn, r_rd, r_yn, r_yd;
    logic signed [S28W-1:0] n_s28, r_s28;

    // Floor wide inputs by keeping their top bits.
    assign w_e = i_quat_w[QUAT_WIDTH-1 -: EFF];
    assign x_e = i_quat_x[QUAT_WIDTH-1 -: EFF];
    assign y_e = i_quat_y[QUAT_WIDTH-1 -: EFF];
    assign z_e = i_quat_z[QUAT_WIDTH-1 -: EFF];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wx <= w_e * x_e;
            r_yz <= y_e * z_e;
            r_xx <= x_e * x_e;
            r_yy <= y_e * y_e;
            r_wz <= w_e * z_e;
            r_xy <= x_e * y_e;
            r_zz <= z_e * z_e;
            r_wy <= w_e * y_e;
            r_zx <= z_e * x_e;
        end
    end

    always_comb begin
        n_rn = (SW'(r_wx) + SW'(r_yz)) <<< 1;
        n_rd = ONE2 - ((SW'(r_xx) + SW'(r_yy)) <<< 1);
        n_yn = (SW'(r_wz) + SW'(r_xy)) <<< 1;
        n_yd = ONE2 - ((SW'(r_yy) + SW'(r_zz)) <<< 1);
        n_s  = (SW'(r_wy) - SW'(r_zx)) <<< 1;
        // Clamp the sine to one so the square root stays real.
        if (n_s > ONE2) begin
            n_s = ONE2;
        end else if (n_s < -ONE2) begin
            n_s = -ONE2;
        end
    end

    // Rescale the sine to Q28.
    generate
        if (FRAC2 >= S28F) begin : g_down
            assign n_s28 = S28W'(n_s >>> (FRAC2 - S28F));
        end else begin : g_up
            assign n_s28 = S28W'(n_s) <<< (S28F - FRAC2);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rn  <= n_rn;
            r_rd  <= n_rd;
            r_yn  <= n_yn;
            r_yd  <= n_yd;
            r_s28 <= n_s28;
        end
    end

    assign o_rn  = r_rn;
    assign o_rd  = r_rd;
    assign o_yn  = r_yn;
    assign o_yd  = r_yd;
    assign o_s28 = r_s28;

endmodule

// ===== hdl/qte_delay.sv =====
// qte_delay.sv
// Enabled shift line that keeps side data in step with the square root.
// No dependencies.
module qte_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_data = r_tap[DEPTH-1];

endmodule

// ===== hdl/qte_isqrt.sv =====
// qte_isqrt.sv
// Pipelined cosine for the pitch: square, 2^56 - s^2, then one restoring
// square-root step per stage. Depends on qte_pkg.
module qte_isqrt (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [qte_pkg::S28_W-1:0]    i_s28,
    output logic        [qte_pkg::ROOT_W-1:0]   o_root
);

    localparam int S28W  = qte_pkg::S28_W;
    localparam int RAD_W = qte_pkg::RAD_W;
    localparam int RW    = RAD_W + 1;
    localparam int NS    = qte_pkg::SQRT_STEPS;

    logic signed [2*S28W-1:0] sq_full;
    logic [RAD_W-1:0] r_sq, r_rad;
    logic [RAD_W-1:0] r_v [NS];
    logic [RW-1:0]    r_r [NS];

    assign sq_full = i_s28 * i_s28;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq  <= sq_full[RAD_W-1:0];
            r_rad <= qte_pkg::RAD_ONE - r_sq;
        end
    end

    generate
        for (genvar j = 0; j < NS; j++) begin : g_step
            localparam logic [RW-1:0] BIT = RW'(1) << (2 * (NS - 1 - j));
            logic [RAD_W-1:0] v_in;
            logic [RW-1:0]    r_in;
            logic [RW-1:0]    trial;

            if (j == 0) begin : g_first
                assign v_in = r_rad;
                assign r_in = '0;
            end else begin : g_next
                assign v_in = r_v[j-1];
                assign r_in = r_r[j-1];
            end

            assign trial = r_in + BIT;

            // Take the bit where the remainder covers the trial value.
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if ({1'b0, v_in} >= trial) begin
                        r_v[j] <= v_in - trial[RAD_W-1:0];
                        r_r[j] <= (r_in >> 1) + BIT;
                    end else begin
                        r_v[j] <= v_in;
                        r_r[j] <= r_in >> 1;
                    end
                end
            end
        end
    endgenerate

    assign o_root = r_r[NS-1][qte_pkg::ROOT_W-1:0];

endmodule

// ===== hdl/qte_atan2.sv =====
// qte_atan2.sv
// Pipelined atan2 in degrees * 2^16: magnitudes, staged normalising shift,
// vectoring CORDIC, then clamp and quadrant mapping. Depends on qte_pkg.
module qte_atan2 #(
    parameter int IN_W = 30
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [IN_W-1:0]             i_num,
    input  logic signed [IN_W-1:0]             i_den,
    output logic signed [qte_pkg::ANG_W-1:0]   o_angle
);

    localparam int MW = (IN_W > qte_pkg::NORM_TOP + 1) ? IN_W : qte_pkg::NORM_TOP + 1;
    localparam int CW = MW + 3;
    localparam int NN = qte_pkg::NORM_STEPS;
    localparam int NC = qte_pkg::CORDIC_STAGES;
    localparam int ZW = qte_pkg::Z_W;
    localparam int AW = qte_pkg::ANG_W;

    logic signed [IN_W:0] num_e, den_e, num_abs, den_abs;
    logic [MW-1:0]        r_nx [NN+1];
    logic [MW-1:0]        r_ny [NN+1];
    qte_pkg::t_atan_flags r_nf [NN+1];
    logic signed [CW-1:0] r_cx [NC];
    logic signed [CW-1:0] r_cy [NC];
    logic signed [ZW-1:0] r_cz [NC];
    qte_pkg::t_atan_flags r_cf [NC];
    qte_pkg::t_atan_flags f_last;
    logic signed [AW-1:0] z_ext, n_ang, r_ang;

    assign num_e   = (IN_W + 1)'(i_num);
    assign den_e   = (IN_W + 1)'(i_den);
    assign num_abs = (num_e < 0) ? -num_e : num_e;
    assign den_abs = (den_e < 0) ? -den_e : den_e;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx[0] <= MW'($unsigned(den_abs));
            r_ny[0] <= MW'($unsigned(num_abs));
            r_nf[0] <= '{neg_num: (i_num < 0), neg_den: (i_den < 0),
                         zero: ((i_num == '0) && (i_den == '0))};
        end
    end

    // Binary-search shift: the larger magnitude ends at or above 2^38.
    generate
        for (genvar n = 1; n <= NN; n++) begin : g_norm
            localparam int SH  = 1 << (NN - n);
            localparam int LIM = qte_pkg::NORM_TOP + 1 - SH;
            logic small_m;

            assign small_m = ((r_nx[n-1] >> LIM) == '0) && ((r_ny[n-1] >> LIM) == '0);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_nx[n] <= small_m ? (r_nx[n-1] << SH) : r_nx[n-1];
                    r_ny[n] <= small_m ? (r_ny[n-1] << SH) : r_ny[n-1];
                    r_nf[n] <= r_nf[n-1];
                end
            end
        end
    endgenerate

    generate
        for (genvar i = 0; i < NC; i++) begin : g_rot
            logic signed [CW-1:0] x_in, y_in;
            logic signed [ZW-1:0] z_in;
            qte_pkg::t_atan_flags f_in;

            if (i == 0) begin : g_first
                assign x_in = $signed(CW'(r_nx[NN]));
                assign y_in = $signed(CW'(r_ny[NN]));
                assign z_in = '0;
                assign f_in = r_nf[NN];
            end else begin : g_next
                assign x_in = r_cx[i-1];
                assign y_in = r_cy[i-1];
                assign z_in = r_cz[i-1];
                assign f_in = r_cf[i-1];
            end

            // Rotate towards the x axis and accumulate the angle.
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!y_in[CW-1]) begin
                        r_cx[i] <= x_in + (y_in >>> i);
                        r_cy[i] <= y_in - (x_in >>> i);
                        r_cz[i] <= z_in + qte_pkg::atan_entry(i);
                    end else begin
                        r_cx[i] <= x_in - (y_in >>> i);
                        r_cy[i] <= y_in + (x_in >>> i);
                        r_cz[i] <= z_in - qte_pkg::atan_entry(i);
                    end
                    r_cf[i] <= f_in;
                end
            end
        end
    endgenerate

    assign z_ext  = AW'(r_cz[NC-1]);
    assign f_last = r_cf[NC-1];

    always_comb begin
        n_ang = z_ext;
        if (z_ext < 0) begin
            n_ang = '0;
        end else if (z_ext > qte_pkg::DEG90) begin
            n_ang = qte_pkg::DEG90;
        end
        if (f_last.neg_den) begin
            n_ang = qte_pkg::DEG180 - n_ang;
        end
        if (f_last.neg_num) begin
            n_ang = -n_ang;
        end
        if (f_last.zero) begin
            n_ang = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang <= n_ang;
        end
    end

    assign o_angle = r_ang;

endmodule

// ===== hdl/quaternion_to_euler_angles.sv =====
// quaternion_to_euler_angles.sv
// Top level: quaternion in, roll / negated pitch / negated yaw out.
// Depends on qte_pkg, qte_front, qte_delay, qte_isqrt, qte_atan2, quaternion_to_euler_angles_assert.svh.
//
//  Channel | Handshake          | Beat contents
//  --------+--------------------+-------------------------------------------
//  input   | i_valid / o_stall  | i_quat_w, i_quat_x, i_quat_y, i_quat_z
//  output  | o_valid / i_stall  | o_roll_deg, o_pitch_deg, o_yaw_deg
//
//  One beat enters per clock while o_stall is low; a result passes through
//  62 register stages (2 front-end stages, 31 for the pitch square root,
//  28 for atan2, one output register, the first loaded by the accepting
//  edge). The square-root chain sets the depth.
//  Reset (synchronous, active low) clears only the valid bits; data
//  registers keep whatever they hold.
//  When a result sits in the output register and i_stall is high, the whole
//  pipeline freezes and o_stall is raised; no beat is dropped or repeated.
`include "quaternion_to_euler_angles_assert.svh"

module quaternion_to_euler_angles #(
    parameter int QUAT_WIDTH      = 16,
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [QUAT_WIDTH-1:0]         i_quat_w,
    input  logic signed [QUAT_WIDTH-1:0]         i_quat_x,
    input  logic signed [QUAT_WIDTH-1:0]         i_quat_y,
    input  logic signed [QUAT_WIDTH-1:0]         i_quat_z,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [qte_pkg::ROLL_W-1:0]    o_roll_deg,
    output logic signed [qte_pkg::PITCH_W-1:0]   o_pitch_deg,
    output logic signed [qte_pkg::YAW_W-1:0]     o_yaw_deg
);

    localparam int SW   = qte_pkg::sum_width(QUAT_WIDTH);
    localparam int S28W = qte_pkg::S28_W;
    localparam int AW   = (SW > S28W) ? SW : S28W;
    localparam int BW   = 4 * SW + S28W;
    localparam int ANGW = qte_pkg::ANG_W;
    localparam int AW1  = ANGW + 1;
    localparam int RS   = qte_pkg::ANG_SCALE_BITS - ANGLE_FRAC_BITS;
    localparam int PIPE_STAGES = 2 + qte_pkg::SQRT_LAT + qte_pkg::ATAN_LAT;
    localparam logic signed [AW1-1:0] HALF = AW1'(1) <<< (RS - 1);

    // Add half an output LSB and floor to the output scale.
    function automatic logic signed [AW1-1:0] round_angle(input logic signed [AW1-1:0] a);
        logic signed [AW1-1:0] s;
        s = a + HALF;
        return s >>> RS;
    endfunction

    logic                          adv;
    logic [PIPE_STAGES-1:0]        r_vld;
    logic                          r_out_valid;
    logic signed [SW-1:0]          rn, rd, yn, yd, rn_d, rd_d, yn_d, yd_d;
    logic signed [S28W-1:0]        s28, s28_d;
    logic [qte_pkg::ROOT_W-1:0]    root;
    logic [BW-1:0]                 side_in, side_out;
    logic signed [ANGW-1:0]        roll_ang, pitch_ang, yaw_ang;
    logic signed [AW1-1:0]         roll_rnd, pitch_rnd, yaw_rnd;
    logic signed [qte_pkg::ROLL_W-1:0]  r_roll;
    logic signed [qte_pkg::PITCH_W-1:0] r_pitch;
    logic signed [qte_pkg::YAW_W-1:0]   r_yaw;

    // Advance everything unless a finished beat is held at the output.
    assign adv     = !(r_out_valid && i_stall);
    assign o_stall = !adv;
    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_vld       <= {r_vld[PIPE_STAGES-2:0], i_valid};
            r_out_valid <= r_vld[PIPE_STAGES-1];
        end
    end

    qte_front #(
        .QUAT_WIDTH (QUAT_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_en     (adv),
        .i_quat_w (i_quat_w),
        .i_quat_x (i_quat_x),
        .i_quat_y (i_quat_y),
        .i_quat_z (i_quat_z),
        .o_rn     (rn),
        .o_rd     (rd),
        .o_yn     (yn),
        .o_yd     (yd),
        .o_s28    (s28)
    );

    qte_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_s28  (s28),
        .o_root (root)
    );

    // Hold the roll/yaw operands and the sine alongside the square root.
    assign side_in = {rn, rd, yn, yd, s28};

    qte_delay #(
        .WIDTH (BW),
        .DEPTH (qte_pkg::SQRT_LAT)
    ) u_side_delay (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_data (side_in),
        .o_data (side_out)
    );

    assign {rn_d, rd_d, yn_d, yd_d, s28_d} = side_out;

    qte_atan2 #(
        .IN_W (AW)
    ) u_roll (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_num   (AW'(rn_d)),
        .i_den   (AW'(rd_d)),
        .o_angle (roll_ang)
    );

    // Pitch is atan2(s, sqrt(1 - s^2)); the cosine is never negative.
    qte_atan2 #(
        .IN_W (AW)
    ) u_pitch (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_num   (AW'(s28_d)),
        .i_den   (AW'($signed({1'b0, root}))),
        .o_angle (pitch_ang)
    );

    qte_atan2 #(
        .IN_W (AW)
    ) u_yaw (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_num   (AW'(yn_d)),
        .i_den   (AW'(yd_d)),
        .o_angle (yaw_ang)
    );

    // Negate pitch and yaw at the full angle scale, then round.
    assign roll_rnd  = round_angle(AW1'(roll_ang));
    assign pitch_rnd = round_angle(-AW1'(pitch_ang));
    assign yaw_rnd   = round_angle(-AW1'(yaw_ang));

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_roll  <= roll_rnd[qte_pkg::ROLL_W-1:0];
            r_pitch <= pitch_rnd[qte_pkg::PITCH_W-1:0];
            r_yaw   <= yaw_rnd[qte_pkg::YAW_W-1:0];
        end
    end

    assign o_roll_deg  = r_roll;
    assign o_pitch_deg = r_pitch;
    assign o_yaw_deg   = r_yaw;

    `QTE_ASSERT_NEXT(a_pipe_hold, o_valid && i_stall, $stable(r_vld), "pipeline moved under a held beat")
    `QTE_ASSERT_NEXT(a_beat_enters, i_valid && !o_stall, r_vld[0], "accepted beat missing from first stage")
    `QTE_ASSERT_NEXT(a_out_from_tail, !o_stall, o_valid == $past(r_vld[PIPE_STAGES-1]), "output valid lost its beat")
    `QTE_ASSERT_SAME(a_stall_only_full, o_stall, r_out_valid, "stall raised with an empty output register")

endmodule
